[rtl/iprl_pkg.sv]
// Shared types and constants for the address range location table.
package iprl_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [31:0] low;
        logic [31:0] high;
        logic [31:0] location;
    } t_entry;

    typedef struct packed {
        logic start;
        logic search_step;
        logic shift_rd;
        logic shift_wr;
        logic write_new;
        logic overwrite;
        logic count_inc;
        logic lookup_done;
        logic clear_ctrs;
        logic rd_pos;
    } t_cmd;

    typedef struct packed {
        logic search_busy;
        logic shift_busy;
        logic pos_valid;
        logic dup;
        logic full;
    } t_status;

endpackage

[rtl/iprl_datapath.sv]
// Datapath: range memory, binary search, insert shifter and counters.
module iprl_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iprl_pkg::t_cmd       i_cmd,
    output iprl_pkg::t_status    o_status,
    input  logic [1:0]           i_opcode,
    input  logic [31:0]          i_address,
    input  logic [31:0]          i_range_low,
    input  logic [31:0]          i_range_high,
    input  logic [31:0]          i_range_location,
    output logic                 o_hit,
    output logic [31:0]          o_location_code,
    output logic [63:0]          o_hits_seen,
    output logic [63:0]          o_misses_seen
);

    iprl_pkg::t_entry r_mem [TABLE_DEPTH];
    iprl_pkg::t_entry r_rd;

    logic [31:0] r_key, r_low, r_loc;
    logic [CW-1:0] r_lo, r_hi, r_cnt, r_sh;
    logic [63:0] r_hits, r_misses;
    logic r_hit;
    logic [31:0] r_loc_out;
    logic r_rd_ok;

    logic [CW-1:0] mid;
    logic [CW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    iprl_pkg::t_entry wr_data;
    logic [CW-1:0] sh_src;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign sh_src = r_sh - CW'(1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = mid;
        if (i_cmd.search_step && (r_lo < r_hi) && !r_rd_ok) begin
            rd_en = 1'b1;
        end
        if (i_cmd.shift_rd) begin
            rd_en   = 1'b1;
            rd_addr = sh_src;
        end
        if (i_cmd.rd_pos) begin
            rd_en   = 1'b1;
            rd_addr = r_lo;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sh;
        wr_data = r_rd;
        if (i_cmd.shift_wr) begin
            wr_en = 1'b1;
        end
        if (i_cmd.write_new || i_cmd.overwrite) begin
            wr_en   = 1'b1;
            wr_addr = r_lo;
            wr_data = '{low: r_low, high: r_key, location: r_loc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_rd_ok  <= 1'b0;
            r_hit    <= 1'b0;
            r_loc_out <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_sh     <= '0;
        end else begin
            r_rd_ok <= rd_en & ~i_cmd.shift_rd & ~i_cmd.rd_pos;
            if (i_cmd.start) begin
                r_key  <= (i_opcode == iprl_pkg::OP_LOAD) ? i_range_high : i_address;
                r_low  <= i_range_low;
                r_loc  <= i_range_location;
                r_lo   <= '0;
                r_hi   <= r_cnt;
                r_sh   <= r_cnt;
                r_hit  <= 1'b0;
                r_loc_out <= '0;
            end
            if (r_rd_ok) begin
                if (r_rd.high < r_key) begin
                    r_lo <= mid + CW'(1);
                end else begin
                    r_hi <= mid;
                end
            end
            if (i_cmd.shift_wr) begin
                r_sh <= sh_src;
            end
            if (i_cmd.count_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.lookup_done) begin
                if (o_status.pos_valid && (r_rd.low <= r_key)) begin
                    r_hit     <= 1'b1;
                    r_loc_out <= r_rd.location;
                    r_hits    <= r_hits + 64'd1;
                end else begin
                    r_misses  <= r_misses + 64'd1;
                end
            end
            if (i_cmd.clear_ctrs) begin
                r_hits   <= '0;
                r_misses <= '0;
            end
        end
    end

    assign o_status.search_busy = (r_lo < r_hi) || r_rd_ok;
    assign o_status.shift_busy  = (r_sh > r_lo);
    assign o_status.pos_valid   = (r_lo < r_cnt);
    assign o_status.dup         = (r_lo < r_cnt) && (r_rd.high == r_key);
    assign o_status.full        = (r_cnt >= CW'(TABLE_DEPTH));

    assign o_hit           = r_hit;
    assign o_location_code = r_loc_out;
    assign o_hits_seen     = r_hits;
    assign o_misses_seen   = r_misses;

endmodule

[rtl/iprl_ctrl.sv]
// Controller state machine sequencing search, insert, lookup and output.
module iprl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  iprl_pkg::t_status    i_status,
    output iprl_pkg::t_cmd       o_cmd,
    output logic                 o_res_load,
    output logic                 o_status_full,
    input  logic                 i_res_free
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_RDPOS  = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;
    localparam logic [3:0] S_SHWR   = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_full, n_full;

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_full        = r_full;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        o_res_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_op   = i_opcode;
                    n_full = 1'b0;
                    if (i_opcode inside {iprl_pkg::OP_LOAD, iprl_pkg::OP_LOOKUP}) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (!i_status.search_busy) begin
                    n_state = S_RDPOS;
                end
            end
            S_RDPOS: begin
                o_cmd.rd_pos = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_op == iprl_pkg::OP_LOOKUP) begin
                    o_cmd.lookup_done = 1'b1;
                    n_state = S_RESULT;
                end else if (i_status.dup) begin
                    o_cmd.overwrite = 1'b1;
                    n_state = S_RESULT;
                end else if (i_status.full) begin
                    n_full  = 1'b1;
                    n_state = S_RESULT;
                end else if (i_status.shift_busy) begin
                    n_state = S_SHRD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SHRD: begin
                o_cmd.shift_rd = 1'b1;
                n_state = S_SHWR;
            end
            S_SHWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!i_status.shift_busy) begin
                    o_cmd.write_new = 1'b1;
                    o_cmd.count_inc = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SHRD;
                end
            end
            S_RESULT: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    if (r_op == iprl_pkg::OP_CLEAR) begin
                        o_cmd.clear_ctrs = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status_full = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_full  <= n_full;
        end
    end

endmodule

[rtl/ip_range_location_lookup.sv]
// Top level of the address range location table.
// Items are taken one at a time; a transfer is accepted only while the controller
// is idle. A lookup runs a binary search of at most ceil(log2(entries+1)) steps
// (11 at 1024 entries): each step needs a memory read with registered data and
// then a compare. A clear or an unused opcode skips the search and goes straight to
// the result. A load that overwrites or is dropped costs the same as a lookup. An
// inserting load moves each entry above the insert point with a read, a write and a
// check, one entry at a time, and writes directly when nothing moves. The result
// sits in an output register, so the next item can be accepted while it waits; that
// item's result is held back until the register is free.
module ip_range_location_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // opcode[1:0], address[33:2], range_low[65:34], range_high[97:66],
    // range_location[129:98], zero fill to 136
    input  logic [135:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // hit[0], location_code[32:1], status[33], hits_seen[97:34],
    // misses_seen[161:98], zero fill to 168
    output logic [167:0]  m_axis_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    iprl_pkg::t_cmd    cmd;
    iprl_pkg::t_status st;
    logic res_load, full;
    logic hit;
    logic [31:0] loc;
    logic [63:0] hits, misses;
    logic r_out_valid;
    logic [167:0] r_out;
    logic res_free;

    assign res_free = !r_out_valid || m_axis_tready;

    iprl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_opcode     (s_axis_tdata[1:0]),
        .i_status     (st),
        .o_cmd        (cmd),
        .o_res_load   (res_load),
        .o_status_full(full),
        .i_res_free   (res_free)
    );

    iprl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW), .CW(CW)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (st),
        .i_opcode        (s_axis_tdata[1:0]),
        .i_address       (s_axis_tdata[33:2]),
        .i_range_low     (s_axis_tdata[65:34]),
        .i_range_high    (s_axis_tdata[97:66]),
        .i_range_location(s_axis_tdata[129:98]),
        .o_hit           (hit),
        .o_location_code (loc),
        .o_hits_seen     (hits),
        .o_misses_seen   (misses)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= {6'd0, misses, hits, full, loc, hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

[rtl/iprl_checker.sv]
// Port-level checker for the address range location table.
module iprl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [167:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_hit_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
        else $error("location without hit");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[33])
        else $error("hit with full status");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !(m_axis_tvalid && $rose(m_axis_tvalid)))
        else $error("result too early");

endmodule

bind ip_range_location_lookup iprl_checker u_iprl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
